### hdl/generational_handle_table_defines.svh
// Assertion macros for the generational handle table, used by ght_ctrl.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef GENERATIONAL_HANDLE_TABLE_DEFINES_SVH
`define GENERATIONAL_HANDLE_TABLE_DEFINES_SVH

// Checks a property on every clock edge outside reset.
`define GHT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks a property on every clock edge, reset included.
`define GHT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/ght_pkg.sv
// Types, codes and helpers for the generational handle table.
// Used by ght_mem, ght_ctrl and generational_handle_table; no dependencies.
package ght_pkg;

    localparam int TABLE_SLOTS_DEF = 16;
    localparam int GEN_SHIFT = 16;
    localparam logic [15:0] IDX_MASK = 16'hFFFF;

    typedef enum logic [3:0] {
        OP_CREATE    = 4'd0,
        OP_DESTROY   = 4'd1,
        OP_LOOKUP    = 4'd2,
        OP_SET_STATE = 4'd3,
        OP_SET_ENTRY = 4'd4,
        OP_SET_EXIT  = 4'd5,
        OP_SET_PORT  = 4'd6,
        OP_FIND      = 4'd7,
        OP_RESET     = 4'd8
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_BAD  = 2'd1,
        ST_FULL = 2'd2,
        ST_NONE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_EVAL,
        S_DONE
    } fsm_t;

    typedef struct packed {
        logic [3:0]  op;
        logic [31:0] pid;
        logic [31:0] subject;
        logic [31:0] aspace;
        logic [2:0]  new_state;
        logic [31:0] entry_tag;
        logic [31:0] exit_code_in;
        logic [31:0] port_tag;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] pid_out;
        logic [31:0] subject_out;
        logic [31:0] aspace_out;
        logic [2:0]  state_out;
        logic [31:0] entry_out;
        logic [31:0] exit_code_out;
        logic [31:0] port_out;
    } rsp_t;

    typedef struct packed {
        logic        live;
        logic [15:0] gen;
        logic [31:0] subject;
        logic [31:0] aspace;
        logic [2:0]  state;
        logic [31:0] entry;
        logic [31:0] exit_val;
        logic [31:0] port;
    } slot_t;

    typedef struct packed {
        logic  we;
        slot_t wdata;
    } mem_wr_t;

    function automatic logic [15:0] next_gen(input logic [15:0] g);
        logic [15:0] n;
        n = g + 16'd1;
        return (n == 16'd0) ? 16'd1 : n;
    endfunction

endpackage

### hdl/ght_mem.sv
// Slot memory of the generational handle table: one address, shared by the write and the registered read.
// Depends on ght_pkg for the slot record type.
module ght_mem #(
    parameter int TABLE_SLOTS = ght_pkg::TABLE_SLOTS_DEF,
    parameter int IDX_W = 1
) (
    input  logic                 clk,
    input  logic [IDX_W-1:0]     addr,
    input  ght_pkg::mem_wr_t     wr,
    output ght_pkg::slot_t       rdata
);
    import ght_pkg::*;

    slot_t mem_reg [TABLE_SLOTS];

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem_reg[addr] <= wr.wdata;
        end
        rdata <= mem_reg[addr];
    end

endmodule

### hdl/ght_ctrl.sv
// Sequencer of the generational handle table: scans and updates the slot memory.
// Depends on ght_pkg and on generational_handle_table_defines.svh.
`include "generational_handle_table_defines.svh"
module ght_ctrl #(
    parameter int TABLE_SLOTS = ght_pkg::TABLE_SLOTS_DEF,
    parameter int IDX_W = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  ght_pkg::req_t        req,
    output logic                 res_valid,
    input  logic                 res_ready,
    output ght_pkg::rsp_t        res,
    output logic [IDX_W-1:0]     mem_addr,
    output ght_pkg::mem_wr_t     mem_wr,
    input  ght_pkg::slot_t       mem_rdata
);
    import ght_pkg::*;

    localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_SLOTS - 1);

    fsm_t state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    req_t req_reg;
    rsp_t res_reg, res_next;

    logic is_single, is_scan, early_done, hit, last, eval_done;
    logic [IDX_W-1:0] slot_addr;

    assign last = (cnt_reg == LAST);
    assign is_single = (req_reg.op == OP_DESTROY) || (req_reg.op == OP_LOOKUP)
                    || (req_reg.op == OP_SET_STATE) || (req_reg.op == OP_SET_ENTRY)
                    || (req_reg.op == OP_SET_EXIT) || (req_reg.op == OP_SET_PORT);
    assign is_scan = (req_reg.op == OP_CREATE) || (req_reg.op == OP_RESET)
                  || (req_reg.op == OP_FIND);
    assign slot_addr = is_single ? req_reg.pid[IDX_W-1:0] : cnt_reg;
    assign hit = mem_rdata.live && (mem_rdata.gen == req_reg.pid[31:GEN_SHIFT]);

    // Items that finish without touching the memory.
    always_comb
    begin
        early_done = 1'b0;
        if (!is_single && !is_scan)
        begin
            early_done = 1'b1;
        end
        else if (req_reg.op == OP_FIND && req_reg.subject == 32'd0)
        begin
            early_done = 1'b1;
        end
        else if (is_single && (req_reg.pid == 32'd0
                 || 32'(req_reg.pid[15:0] & IDX_MASK) >= 32'(TABLE_SLOTS)))
        begin
            early_done = 1'b1;
        end
    end

    always_comb
    begin
        eval_done = 1'b1;
        case (req_reg.op)
            OP_CREATE: eval_done = !mem_rdata.live || last;
            OP_FIND:   eval_done = (mem_rdata.live && mem_rdata.subject == req_reg.subject)
                                   || last;
            OP_RESET:  eval_done = last;
            default:   eval_done = 1'b1;
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: if (last) state_next = S_IDLE;
            S_IDLE:  if (req_valid) state_next = S_RD;
            S_RD:    state_next = early_done ? S_DONE : S_EVAL;
            S_EVAL:  state_next = eval_done ? S_DONE : S_RD;
            S_DONE:  if (res_ready) state_next = S_IDLE;
            default: state_next = S_CLEAR;
        endcase
    end

    // Memory access, counter and result.
    always_comb
    begin
        mem_wr.we = 1'b0;
        mem_wr.wdata = mem_rdata;
        mem_addr = slot_addr;
        cnt_next = cnt_reg;
        res_next = res_reg;
        case (state_reg)
            S_CLEAR:
            begin
                mem_addr = cnt_reg;
                mem_wr.we = 1'b1;
                mem_wr.wdata = '0;
                mem_wr.wdata.gen = 16'd1;
                cnt_next = last ? '0 : cnt_reg + 1'b1;
            end
            S_IDLE:
            begin
                cnt_next = '0;
            end
            S_RD:
            begin
                res_next = '0;
                if (req_reg.op == OP_FIND && req_reg.subject == 32'd0)
                begin
                    res_next.status = ST_NONE;
                end
                else if (is_single && early_done)
                begin
                    res_next.status = ST_BAD;
                end
            end
            S_EVAL:
            begin
                if (!eval_done)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                case (req_reg.op)
                    OP_CREATE:
                    begin
                        if (!mem_rdata.live)
                        begin
                            mem_wr.we = 1'b1;
                            mem_wr.wdata = '0;
                            mem_wr.wdata.live = 1'b1;
                            mem_wr.wdata.gen = mem_rdata.gen;
                            mem_wr.wdata.subject = req_reg.subject;
                            mem_wr.wdata.aspace = req_reg.aspace;
                            res_next.pid_out = {mem_rdata.gen, 16'(cnt_reg)};
                        end
                        else if (last)
                        begin
                            res_next.status = ST_FULL;
                        end
                    end
                    OP_FIND:
                    begin
                        if (mem_rdata.live && mem_rdata.subject == req_reg.subject)
                        begin
                            res_next.aspace_out = mem_rdata.aspace;
                        end
                        else if (last)
                        begin
                            res_next.status = ST_NONE;
                        end
                    end
                    OP_RESET:
                    begin
                        mem_wr.we = 1'b1;
                        mem_wr.wdata = '0;
                        mem_wr.wdata.gen = next_gen(mem_rdata.gen);
                    end
                    default:
                    begin
                        if (!hit)
                        begin
                            res_next.status = ST_BAD;
                        end
                        else
                        begin
                            case (req_reg.op)
                                OP_DESTROY:
                                begin
                                    res_next.subject_out = mem_rdata.subject;
                                    mem_wr.we = 1'b1;
                                    mem_wr.wdata.live = 1'b0;
                                    mem_wr.wdata.gen = next_gen(mem_rdata.gen);
                                    mem_wr.wdata.subject = '0;
                                    mem_wr.wdata.aspace = '0;
                                end
                                OP_LOOKUP:
                                begin
                                    res_next.subject_out = mem_rdata.subject;
                                    res_next.aspace_out = mem_rdata.aspace;
                                    res_next.state_out = mem_rdata.state;
                                    res_next.entry_out = mem_rdata.entry;
                                    res_next.exit_code_out = mem_rdata.exit_val;
                                    res_next.port_out = mem_rdata.port;
                                end
                                OP_SET_STATE:
                                begin
                                    mem_wr.we = 1'b1;
                                    mem_wr.wdata.state = req_reg.new_state;
                                end
                                OP_SET_ENTRY:
                                begin
                                    mem_wr.we = 1'b1;
                                    mem_wr.wdata.entry = req_reg.entry_tag;
                                end
                                OP_SET_EXIT:
                                begin
                                    mem_wr.we = 1'b1;
                                    mem_wr.wdata.exit_val = req_reg.exit_code_in;
                                end
                                default:
                                begin
                                    mem_wr.we = 1'b1;
                                    mem_wr.wdata.port = req_reg.port_tag;
                                end
                            endcase
                        end
                    end
                endcase
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && req_valid)
        begin
            req_reg <= req;
        end
        res_reg <= res_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res = res_reg;

    `GHT_ASSERT(a_wr_state, mem_wr.we |-> (state_reg == S_CLEAR || state_reg == S_EVAL), "memory written outside clear or evaluate")
    `GHT_ASSERT(a_gen_nonzero, mem_wr.we |-> (mem_wr.wdata.gen != 16'd0), "generation zero written")
    `GHT_ASSERT(a_accept_read, (req_valid && !req_stall) |=> (state_reg == S_RD), "accepted transaction not started")
    `GHT_ASSERT(a_create_gen, (res_valid && req_reg.op == OP_CREATE && res_reg.status == ST_OK) |-> (res_reg.pid_out[31:16] != 16'd0), "created handle has generation zero")

endmodule

### hdl/generational_handle_table.sv
// Generational handle table: issues 32-bit handles {generation, slot index} for a
// fixed slot table. After reset the block first clears its slot memory, one slot a
// cycle, and takes no transaction until that is done. One request is worked at a
// time. Every slot access is a read of the single-port slot memory followed by an
// evaluate state. A handle operation (destroy, lookup, set) visits its one slot;
// create, find and table reset visit slots in turn, up to TABLE_SLOTS (table reset
// always visits all). Unused codes, a bad handle index and find of subject zero
// answer straight after the read, with no evaluate state. The result sits in an
// output register, so the next request is taken while a finished result still
// waits for the consumer.
// Depends on ght_pkg, ght_ctrl and ght_mem.
module generational_handle_table #(
    parameter int TABLE_SLOTS = ght_pkg::TABLE_SLOTS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  ght_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output ght_pkg::rsp_t  rsp
);
    import ght_pkg::*;

    localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

    logic             res_valid;
    logic             res_ready;
    rsp_t             res;
    logic [IDX_W-1:0] mem_addr;
    mem_wr_t          mem_wr;
    slot_t            mem_rdata;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_t             rsp_reg;

    ght_ctrl #(
        .TABLE_SLOTS(TABLE_SLOTS),
        .IDX_W(IDX_W)
    ) u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res(res),
        .mem_addr(mem_addr),
        .mem_wr(mem_wr),
        .mem_rdata(mem_rdata)
    );

    ght_mem #(
        .TABLE_SLOTS(TABLE_SLOTS),
        .IDX_W(IDX_W)
    ) u_mem (
        .clk(clk),
        .addr(mem_addr),
        .wr(mem_wr),
        .rdata(mem_rdata)
    );

    // The output register frees up when it is empty or being taken this cycle.
    assign res_ready = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (res_ready)
        begin
            rsp_valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp = rsp_reg;

endmodule

### tb/tb_top.sv
// Self-checking testbench for the generational handle table.
// Depends on ght_pkg and the generational_handle_table RTL only.
`timescale 1ns / 1ps

module tb_top;
    import ght_pkg::*;

    localparam int NSLOTS = 16;
    localparam int IDLE_LIMIT = 20000;

    logic  clk;
    logic  rst_n;
    logic  req_valid;
    logic  req_stall;
    req_t  req;
    logic  rsp_valid;
    logic  rsp_stall;
    rsp_t  rsp;

    // Shadow copy of the slot table, updated as each transaction is accepted.
    logic        sh_live [NSLOTS];
    logic [15:0] sh_gen [NSLOTS];
    logic [31:0] sh_subject [NSLOTS];
    logic [31:0] sh_aspace [NSLOTS];
    logic [2:0]  sh_state [NSLOTS];
    logic [31:0] sh_entry [NSLOTS];
    logic [31:0] sh_exit [NSLOTS];
    logic [31:0] sh_port [NSLOTS];

    rsp_t pending_rsps[$];
    int   mismatches;
    int   quiet_cycles;
    bit   rsp_idle_on;
    bit   req_idle_on;
    bit   hold_rsp;

    generational_handle_table u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [15:0] bump_gen(input logic [15:0] g);
        logic [15:0] n;
        n = g + 16'd1;
        return (n == 16'd0) ? 16'd1 : n;
    endfunction

    function automatic void wipe_slot(input int i);
        sh_live[i] = 1'b0;
        sh_subject[i] = '0;
        sh_aspace[i] = '0;
        sh_state[i] = '0;
        sh_entry[i] = '0;
        sh_exit[i] = '0;
        sh_port[i] = '0;
    endfunction

    // Works out the answer to one request and applies its effect to the shadow table.
    function automatic rsp_t table_answer(input req_t r);
        rsp_t a;
        int   idx;
        bit   ok;
        a = '0;
        a.status = ST_OK;
        case (op_t'(r.op))
            OP_CREATE:
            begin
                a.status = ST_FULL;
                for (int i = 0; i < NSLOTS; i++)
                begin
                    if (!sh_live[i] && a.status == ST_FULL)
                    begin
                        wipe_slot(i);
                        sh_live[i] = 1'b1;
                        sh_subject[i] = r.subject;
                        sh_aspace[i] = r.aspace;
                        a.pid_out = {sh_gen[i], 16'(i)};
                        a.status = ST_OK;
                    end
                end
            end
            OP_FIND:
            begin
                a.status = ST_NONE;
                if (r.subject != 0)
                begin
                    for (int i = 0; i < NSLOTS; i++)
                    begin
                        if (a.status == ST_NONE && sh_live[i] && sh_subject[i] == r.subject)
                        begin
                            a.status = ST_OK;
                            a.aspace_out = sh_aspace[i];
                        end
                    end
                end
            end
            OP_RESET:
            begin
                for (int i = 0; i < NSLOTS; i++)
                begin
                    sh_gen[i] = bump_gen(sh_gen[i]);
                    wipe_slot(i);
                end
            end
            OP_DESTROY, OP_LOOKUP, OP_SET_STATE, OP_SET_ENTRY, OP_SET_EXIT, OP_SET_PORT:
            begin
                idx = int'(r.pid[15:0]);
                ok = (r.pid != 0) && (idx < NSLOTS);
                if (ok)
                    ok = sh_live[idx] && (sh_gen[idx] == r.pid[31:16]);
                if (!ok)
                    a.status = ST_BAD;
                else
                begin
                    case (op_t'(r.op))
                        OP_DESTROY:
                        begin
                            a.subject_out = sh_subject[idx];
                            sh_live[idx] = 1'b0;
                            sh_gen[idx] = bump_gen(sh_gen[idx]);
                            sh_subject[idx] = '0;
                            sh_aspace[idx] = '0;
                        end
                        OP_LOOKUP:
                        begin
                            a.subject_out = sh_subject[idx];
                            a.aspace_out = sh_aspace[idx];
                            a.state_out = sh_state[idx];
                            a.entry_out = sh_entry[idx];
                            a.exit_code_out = sh_exit[idx];
                            a.port_out = sh_port[idx];
                        end
                        OP_SET_STATE: sh_state[idx] = r.new_state;
                        OP_SET_ENTRY: sh_entry[idx] = r.entry_tag;
                        OP_SET_EXIT:  sh_exit[idx] = r.exit_code_in;
                        default:      sh_port[idx] = r.port_tag;
                    endcase
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Sends one transaction, with an optional random gap before it.
    task automatic send_req(input req_t r);
        int gap;
        if (req_idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 14);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        // The expectation is formed at acceptance, in the same order the block sees it.
        pending_rsps.push_back(table_answer(r));
    endtask

    task automatic pause_req();
        req_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        pause_req();
        while (pending_rsps.size() != 0)
            @(posedge clk);
    endtask

    // Random fields across the full range of every input bit but the op, which is given.
    function automatic req_t noise_req(input logic [3:0] op);
        req_t r;
        r.op = op;
        r.pid = $urandom();
        r.subject = $urandom();
        r.aspace = $urandom();
        r.new_state = 3'($urandom());
        r.entry_tag = $urandom();
        r.exit_code_in = $urandom();
        r.port_tag = $urandom();
        return r;
    endfunction

    // A handle that usually points at a live slot, sometimes stale or out of range.
    function automatic logic [31:0] pick_handle();
        int i;
        int k;
        i = $urandom_range(0, NSLOTS - 1);
        k = $urandom_range(0, 9);
        if (k < 7)
        begin
            for (int j = 0; j < NSLOTS; j++)
            begin
                if (sh_live[(i + j) % NSLOTS])
                    return {sh_gen[(i + j) % NSLOTS], 16'((i + j) % NSLOTS)};
            end
            return {sh_gen[i], 16'(i)};
        end
        else if (k == 7)
            return {sh_gen[i] - 16'd1, 16'(i)};
        else if (k == 8)
            return {sh_gen[i], 16'($urandom_range(NSLOTS, 16'hFFFF))};
        return $urandom();
    endfunction

    function automatic logic [31:0] live_subject();
        int i;
        i = $urandom_range(0, NSLOTS - 1);
        if (sh_live[i] && $urandom_range(0, 3) != 0)
            return sh_subject[i];
        return $urandom_range(0, 3) == 0 ? 32'd0 : $urandom_range(1, 40);
    endfunction

    // Directed: every op, extremes, full table, stale handle, zero subject, reset.
    task automatic test_directed();
        req_t r;
        logic [31:0] h0;
        r = '0;
        r.op = OP_LOOKUP;
        send_req(r);
        r.op = OP_FIND;
        send_req(r);
        r.op = 4'd15;
        send_req(noise_req(4'd15));
        for (int i = 0; i < NSLOTS; i++)
        begin
            r = noise_req(OP_CREATE);
            r.subject = (i == 0) ? 32'hFFFF_FFFF : 32'(i);
            send_req(r);
        end
        send_req(noise_req(OP_CREATE));
        h0 = {16'd1, 16'd0};
        r = '1;
        r.op = OP_SET_STATE;  r.pid = h0; send_req(r);
        r.op = OP_SET_ENTRY;  send_req(r);
        r.op = OP_SET_EXIT;   send_req(r);
        r.op = OP_SET_PORT;   send_req(r);
        r.op = OP_LOOKUP;     send_req(r);
        r.op = OP_FIND;       r.subject = 32'hFFFF_FFFF; send_req(r);
        r.op = OP_DESTROY;    send_req(r);
        r.op = OP_LOOKUP;     send_req(r);
        r.op = OP_RESET;      send_req(r);
        drain();
    endtask

    // Random mix weighted toward well-formed handle traffic.
    task automatic test_random(input int count);
        req_t r;
        int k;
        for (int n = 0; n < count; n++)
        begin
            k = $urandom_range(0, 99);
            if (k < 22)
                r = noise_req(OP_CREATE);
            else if (k < 36)
                r = noise_req(OP_DESTROY);
            else if (k < 52)
                r = noise_req(OP_LOOKUP);
            else if (k < 72)
                r = noise_req(4'($urandom_range(OP_SET_STATE, OP_SET_PORT)));
            else if (k < 84)
                r = noise_req(OP_FIND);
            else if (k < 86)
                r = noise_req(OP_RESET);
            else if (k < 89)
                r = noise_req(4'($urandom_range(9, 15)));
            else
                r = noise_req(4'($urandom_range(1, 6)));
            if (k < 84 && r.op != OP_CREATE && r.op != OP_FIND)
                r.pid = pick_handle();
            if (r.op == OP_FIND && $urandom_range(0, 4) != 0)
                r.subject = live_subject();
            if (r.op == OP_CREATE && $urandom_range(0, 1) == 0)
                r.subject = $urandom_range(1, 40);
            send_req(r);
        end
    endtask

    // The receiver holds off for a long stretch while requests keep coming.
    task automatic test_backpressure();
        hold_rsp = 1'b1;
        test_random(12);
        hold_rsp = 1'b0;
        drain();
    endtask

    // Result side: compares each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsps.size() == 0)
            begin
                report_mismatch("unexpected result", 32'(rsp.status), 32'd0);
            end
            else
            begin
                want = pending_rsps.pop_front();
                if (rsp.status !== want.status)
                    report_mismatch("status", 32'(rsp.status), 32'(want.status));
                if (rsp.pid_out !== want.pid_out)
                    report_mismatch("pid_out", rsp.pid_out, want.pid_out);
                if (rsp.subject_out !== want.subject_out)
                    report_mismatch("subject_out", rsp.subject_out, want.subject_out);
                if (rsp.aspace_out !== want.aspace_out)
                    report_mismatch("aspace_out", rsp.aspace_out, want.aspace_out);
                if (rsp.state_out !== want.state_out)
                    report_mismatch("state_out", 32'(rsp.state_out), 32'(want.state_out));
                if (rsp.entry_out !== want.entry_out)
                    report_mismatch("entry_out", rsp.entry_out, want.entry_out);
                if (rsp.exit_code_out !== want.exit_code_out)
                    report_mismatch("exit_code_out", rsp.exit_code_out, want.exit_code_out);
                if (rsp.port_out !== want.port_out)
                    report_mismatch("port_out", rsp.port_out, want.port_out);
            end
        end
    end

    // Receiver stall: random bursts, or a long hold when asked.
    initial
    begin
        int burst;
        rsp_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_rsp)
            begin
                rsp_stall <= 1'b1;
                repeat (300) @(posedge clk);
                rsp_stall <= 1'b0;
                wait (!hold_rsp);
            end
            else if (rsp_idle_on && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 14);
                rsp_stall <= 1'b1;
                repeat (burst) @(posedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    // Watchdog on cycles without any accepted transaction.
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        mismatches = 0;
        quiet_cycles = 0;
        rsp_idle_on = 1'b1;
        req_idle_on = 1'b1;
        hold_rsp = 1'b0;
        rst_n = 1'b0;
        req_valid <= 1'b0;
        req <= '0;
        for (int i = 0; i < NSLOTS; i++)
        begin
            wipe_slot(i);
            sh_gen[i] = 16'd1;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_backpressure();
        test_random(1200);
        drain();
        // Final stretch with no idling on either side.
        rsp_idle_on = 1'b0;
        req_idle_on = 1'b0;
        test_random(450);
        drain();
        repeat (60) @(posedge clk);
        if (mismatches == 0 && pending_rsps.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

### filelist.f
+incdir+hdl
hdl/ght_pkg.sv
hdl/ght_mem.sv
hdl/ght_ctrl.sv
hdl/generational_handle_table.sv
tb/tb_top.sv
